### sv/ubjv_pkg.sv
package ubjv_pkg;

    localparam int MODE_W  = 4;
    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int MAX_BYTES = 10;
    localparam int LEN_W   = 4;

    // value type codes
    localparam logic [MODE_W-1:0] MODE_NULL   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_BOOL   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_INT8   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_INT16  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_INT32  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_INT64  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_FLOAT  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 4'd7;
    localparam logic [MODE_W-1:0] MODE_STRING = 4'd8;

    // type markers
    localparam logic [BYTE_W-1:0] MARK_NULL    = 8'h5A; // Z
    localparam logic [BYTE_W-1:0] MARK_TRUE    = 8'h54; // T
    localparam logic [BYTE_W-1:0] MARK_FALSE   = 8'h46; // F
    localparam logic [BYTE_W-1:0] MARK_INT8    = 8'h42; // B
    localparam logic [BYTE_W-1:0] MARK_INT16   = 8'h69; // i
    localparam logic [BYTE_W-1:0] MARK_INT32   = 8'h49; // I
    localparam logic [BYTE_W-1:0] MARK_INT64   = 8'h4C; // L
    localparam logic [BYTE_W-1:0] MARK_FLOAT   = 8'h64; // d
    localparam logic [BYTE_W-1:0] MARK_DOUBLE  = 8'h44; // D
    localparam logic [BYTE_W-1:0] MARK_STRING  = 8'h73; // s

    localparam logic [7:0]  EXP8_ONES  = 8'hFF;
    localparam logic [10:0] EXP11_ONES = 11'h7FF;

    // string length limits, first size whose maximum exceeds the length
    localparam logic [VALUE_W-1:0] LIM_INT8  = 64'd127;
    localparam logic [VALUE_W-1:0] LIM_INT16 = 64'd32767;
    localparam logic [VALUE_W-1:0] LIM_INT32 = 64'd2147483647;

    typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] byte_vec_t;

    // one encoded value, byte 0 goes out first
    typedef struct packed {
        byte_vec_t         bytes;
        logic [LEN_W-1:0]  len;
    } frame_t;

endpackage

### sv/ubjv_if.sv
interface ubjv_in_if
    import ubjv_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

interface ubjv_out_if
    import ubjv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

### sv/ubjv_format.sv
module ubjv_format
    import ubjv_pkg::*;
(
    input  logic [MODE_W-1:0]  mode,
    input  logic [VALUE_W-1:0] value,
    output frame_t             frame
);

    logic [BYTE_W-1:0] mark0;
    logic [BYTE_W-1:0] mark1;
    logic [LEN_W-1:0]  hdr;
    logic [LEN_W-1:0]  nb;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  k;

    // header bytes and payload size
    always_comb
    begin
        mark0 = MARK_NULL;
        mark1 = MARK_NULL;
        hdr   = 4'd1;
        nb    = 4'd0;
        unique case (mode)
            MODE_BOOL:   mark0 = value[0] ? MARK_TRUE : MARK_FALSE;
            MODE_INT8:
            begin
                mark0 = MARK_INT8;
                nb    = 4'd1;
            end
            MODE_INT16:
            begin
                mark0 = MARK_INT16;
                nb    = 4'd2;
            end
            MODE_INT32:
            begin
                mark0 = MARK_INT32;
                nb    = 4'd4;
            end
            MODE_INT64:
            begin
                mark0 = MARK_INT64;
                nb    = 4'd8;
            end
            MODE_FLOAT:
            begin
                if (value[30:23] != EXP8_ONES)
                begin
                    mark0 = MARK_FLOAT;
                    nb    = 4'd4;
                end
            end
            MODE_DOUBLE:
            begin
                if (value[62:52] != EXP11_ONES)
                begin
                    mark0 = MARK_DOUBLE;
                    nb    = 4'd8;
                end
            end
            MODE_STRING:
            begin
                mark0 = MARK_STRING;
                hdr   = 4'd2;
                if (value < LIM_INT8)
                begin
                    mark1 = MARK_INT8;
                    nb    = 4'd1;
                end
                else if (value < LIM_INT16)
                begin
                    mark1 = MARK_INT16;
                    nb    = 4'd2;
                end
                else if (value < LIM_INT32)
                begin
                    mark1 = MARK_INT32;
                    nb    = 4'd4;
                end
                else
                begin
                    mark1 = MARK_INT64;
                    nb    = 4'd8;
                end
            end
            default:     mark0 = MARK_NULL;
        endcase
    end

    // lay out markers then payload, most significant byte first
    always_comb
    begin
        frame.len = hdr + nb;
        pos = '0;
        k   = '0;
        for (int j = 0; j < MAX_BYTES; j++)
        begin
            pos = LEN_W'(j);
            k   = nb - 4'd1 - (pos - hdr);
            if (j == 0)
                frame.bytes[j] = mark0;
            else if (pos < hdr)
                frame.bytes[j] = mark1;
            else if (pos < hdr + nb)
                frame.bytes[j] = value[BYTE_W*k[2:0] +: BYTE_W];
            else
                frame.bytes[j] = '0;
        end
    end

endmodule

### sv/ubjv_serializer.sv
module ubjv_serializer
    import ubjv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_ready,
    input  frame_t      frame,
    ubjv_out_if.source  result
);

    byte_vec_t         shift_reg;
    byte_vec_t         shift_next;
    logic [LEN_W-1:0]  remain_reg;
    logic [LEN_W-1:0]  remain_next;
    logic              take;

    assign take        = result.valid && result.ready;
    // free when empty or when the final byte leaves this cycle
    assign frame_ready = (remain_reg == '0) || (remain_reg == 4'd1 && result.ready);

    assign result.valid    = remain_reg != '0;
    assign result.out_byte = shift_reg[0];
    assign result.last     = remain_reg == 4'd1;

    always_comb
    begin
        shift_next  = shift_reg;
        remain_next = remain_reg;
        if (frame_valid && frame_ready)
        begin
            shift_next  = frame.bytes;
            remain_next = frame.len;
        end
        else if (take)
        begin
            shift_next  = shift_reg >> BYTE_W;
            remain_next = remain_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remain_reg <= '0;
        else
            remain_reg <= remain_next;
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

### sv/ubjson_value_encoder.sv
// a request passes the input stage register, then is loaded into the output shifter register
// throughput: one byte per cycle while the receiver is ready; a value is 1 to 10 bytes
// (null, bool, special floats 1; int8 2; int16 3; int32 and float 5; int64 and double 9;
// string header 3, 4, 6 or 10), paced by the single byte-wide output shifter
// reset: asynchronous active low, empties the input and output stages, no other state
module ubjson_value_encoder
    import ubjv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ubjv_in_if.sink     item,
    ubjv_out_if.source  result
);

    // input stage: holds one request while the shifter drains the previous value
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [VALUE_W-1:0] value_reg;

    logic               frame_ready;
    frame_t             frame;
    logic               item_take;

    // the stage can refill in the same cycle its request moves on
    assign item.ready = !in_valid_reg || frame_ready;
    assign item_take  = item.valid && item.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_take)
            in_valid_next = 1'b1;
        else if (frame_ready)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            mode_reg  <= item.mode;
            value_reg <= item.value;
        end
    end

    // marker selection and byte layout, all combinational
    ubjv_format u_format (
        .mode  (mode_reg),
        .value (value_reg),
        .frame (frame)
    );

    // output shifter, one byte per handshake, last flag on the final byte
    ubjv_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (in_valid_reg),
        .frame_ready (frame_ready),
        .frame       (frame),
        .result      (result)
    );

endmodule

### dv/ubjson_value_encoder_test.sv
module ubjson_value_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ubjv_pkg::*;

    localparam int PERIOD       = 10;
    localparam int RESET_CYCLES = 5;
    localparam int PHASE_ITEMS  = 17;     // five random phases plus the table, about 110 requests
    localparam int LONG_HOLD    = 80;     // receiver back-pressure stretch, in cycles
    localparam int IDLE_LIMIT   = 2000;   // cycles without any handshake while busy
    localparam int TAIL_CYCLES  = 20;     // quiet time after the last byte

    // mode codes the encoder treats as null
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

    localparam logic [VALUE_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // one encoded byte as the output channel should carry it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } enc_byte_t;

    // one request; a nonzero byte count means the bytes are typed in below
    typedef struct {
        logic [MODE_W-1:0]       mode;
        logic [VALUE_W-1:0]      value;
        int                      n;
        logic [0:2][BYTE_W-1:0]  lit;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ubjv_in_if  item_bus ();
    ubjv_out_if res_bus ();

    ubjson_value_encoder i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (res_bus)
    );

    always #(PERIOD / 2) clk = ~clk;

    // bytes still owed by the encoder, oldest first
    enc_byte_t pending_bytes[$];
    request_t  directed_requests[$];
    enc_byte_t want_byte;

    int errors = 0;
    int requests_sent = 0;
    int bytes_checked = 0;
    int string_headers = 0;
    int nonfinite_floats = 0;

    // idling knobs, percent of cycles, set by the stimulus process
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // long hold-off: the stimulus bumps hold_seq, the receiver counts it down
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int idle_cycles = 0;

    // ---------------------------------------------------------------
    // predictor: UBJSON encoding of one typed value, byte by byte
    // ---------------------------------------------------------------
    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back('{data: b, last: 1'b0});
    endfunction

    // big-endian payload, most significant byte first
    function automatic void push_be(input logic [VALUE_W-1:0] v, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            push_byte(v[i*8 +: 8]);
    endfunction

    function automatic void encode_value(input logic [MODE_W-1:0] mode,
                                         input logic [VALUE_W-1:0] value);
        case (mode)
            MODE_BOOL:
                push_byte(value[0] ? MARK_TRUE : MARK_FALSE);
            MODE_INT8:
            begin
                push_byte(MARK_INT8);
                push_be(value, 1);
            end
            MODE_INT16:
            begin
                push_byte(MARK_INT16);
                push_be(value, 2);
            end
            MODE_INT32:
            begin
                push_byte(MARK_INT32);
                push_be(value, 4);
            end
            MODE_INT64:
            begin
                push_byte(MARK_INT64);
                push_be(value, 8);
            end
            MODE_FLOAT:
            begin
                // inf and nan collapse to null
                if (value[30:23] == EXP8_ONES)
                    push_byte(MARK_NULL);
                else
                begin
                    push_byte(MARK_FLOAT);
                    push_be(value, 4);
                end
            end
            MODE_DOUBLE:
            begin
                if (value[62:52] == EXP11_ONES)
                    push_byte(MARK_NULL);
                else
                begin
                    push_byte(MARK_DOUBLE);
                    push_be(value, 8);
                end
            end
            MODE_STRING:
            begin
                // length goes out in the first size whose max is strictly above it
                push_byte(MARK_STRING);
                if (value < LIM_INT8)
                begin
                    push_byte(MARK_INT8);
                    push_be(value, 1);
                end
                else if (value < LIM_INT16)
                begin
                    push_byte(MARK_INT16);
                    push_be(value, 2);
                end
                else if (value < LIM_INT32)
                begin
                    push_byte(MARK_INT32);
                    push_be(value, 4);
                end
                else
                begin
                    push_byte(MARK_INT64);
                    push_be(value, 8);
                end
            end
            // null and the unused codes
            default:
                push_byte(MARK_NULL);
        endcase
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // directed table: typed-in bytes where obvious, predictor elsewhere
    // ---------------------------------------------------------------
    function automatic void add_request(input logic [MODE_W-1:0] mode,
                                        input logic [VALUE_W-1:0] value,
                                        input int n,
                                        input logic [0:2][BYTE_W-1:0] lit);
        directed_requests.push_back('{mode: mode, value: value, n: n, lit: lit});
    endfunction

    function automatic void build_directed();
        // plain null and the unused codes, both ends of the mode field
        add_request(MODE_NULL, 64'd0, 1, {MARK_NULL, 8'h00, 8'h00});
        add_request(MODE_UNUSED_LO, 64'd5, 1, {MARK_NULL, 8'h00, 8'h00});
        add_request(MODE_UNUSED_HI, ALL_ONES, 1, {MARK_NULL, 8'h00, 8'h00});
        // bool looks at bit 0 only
        add_request(MODE_BOOL, 64'd1, 1, {MARK_TRUE, 8'h00, 8'h00});
        add_request(MODE_BOOL, ALL_ONES - 64'd1, 1, {MARK_FALSE, 8'h00, 8'h00});
        // narrow int drops the upper bits
        add_request(MODE_INT8, 64'hFF, 2, {MARK_INT8, 8'hFF, 8'h00});
        add_request(MODE_INT8, ALL_ONES - 64'hFF, 2, {MARK_INT8, 8'h00, 8'h00});
        add_request(MODE_INT16, 64'h8000, 0, '0);
        add_request(MODE_INT32, 64'h0123_4567_89AB_CDEF, 0, '0);
        add_request(MODE_INT64, ALL_ONES, 0, '0);
        // non-finite floats become null, upper half of a single is ignored
        add_request(MODE_FLOAT, 64'h7F80_0000, 1, {MARK_NULL, 8'h00, 8'h00});
        add_request(MODE_FLOAT, 64'hFFFF_FFFF_7FC0_0000, 1, {MARK_NULL, 8'h00, 8'h00});
        add_request(MODE_FLOAT, 64'h7F7F_FFFF, 0, '0);
        add_request(MODE_FLOAT, 64'hFFFF_FFFF_0080_0000, 0, '0);
        add_request(MODE_DOUBLE, 64'h7FF0_0000_0000_0000, 1, {MARK_NULL, 8'h00, 8'h00});
        add_request(MODE_DOUBLE, 64'hFFF8_0000_0000_0001, 1, {MARK_NULL, 8'h00, 8'h00});
        add_request(MODE_DOUBLE, 64'h7FEF_FFFF_FFFF_FFFF, 0, '0);
        // string length on each side of every size boundary
        add_request(MODE_STRING, 64'd0, 3, {MARK_STRING, MARK_INT8, 8'h00});
        add_request(MODE_STRING, LIM_INT8 - 64'd1, 0, '0);
        add_request(MODE_STRING, LIM_INT8, 0, '0);
        add_request(MODE_STRING, LIM_INT16 - 64'd1, 0, '0);
        add_request(MODE_STRING, LIM_INT16, 0, '0);
        add_request(MODE_STRING, LIM_INT32 - 64'd1, 0, '0);
        add_request(MODE_STRING, LIM_INT32, 0, '0);
        add_request(MODE_STRING, ALL_ONES, 0, '0);
    endfunction

    // random request, shaped so that special floats and size edges come up often
    function automatic request_t random_request();
        request_t r;
        r.n = 0;
        r.lit = '0;
        r.value = {$urandom, $urandom};
        if ($urandom_range(99) < 8)
            r.mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
        else
            r.mode = MODE_W'($urandom_range(MODE_STRING, MODE_NULL));
        if (r.mode == MODE_FLOAT && $urandom_range(3) == 0)
            r.value[30:23] = EXP8_ONES;
        if (r.mode == MODE_DOUBLE && $urandom_range(3) == 0)
            r.value[62:52] = EXP11_ONES;
        if (r.mode == MODE_STRING)
        begin
            case ($urandom_range(4))
                0: r.value = 64'($urandom_range(200));
                1: r.value = LIM_INT8 - 64'd2 + 64'($urandom_range(4));
                2: r.value = LIM_INT16 - 64'd2 + 64'($urandom_range(4));
                3: r.value = LIM_INT32 - 64'd2 + 64'($urandom_range(4));
                default: ;  // full 64-bit length
            endcase
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // sender: offer one request, hold it until the handshake
    // ---------------------------------------------------------------
    task automatic send_request(input request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.mode  <= r.mode;
        item_bus.value <= r.value;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        // request taken at this edge
        requests_sent++;
        if (r.mode == MODE_STRING)
            string_headers++;
        if ((r.mode == MODE_FLOAT && r.value[30:23] == EXP8_ONES) ||
            (r.mode == MODE_DOUBLE && r.value[62:52] == EXP11_ONES))
            nonfinite_floats++;
        if (r.n == 0)
            encode_value(r.mode, r.value);
        else
            for (int k = 0; k < r.n; k++)
                pending_bytes.push_back('{data: r.lit[k], last: (k == r.n - 1)});
    endtask

    // sender goes quiet until every owed byte has come out
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct,
                             input bit long_hold, input int count);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        // receiver freezes while the sender keeps pushing, so the input stalls
        if (long_hold)
            hold_seq++;
        for (int i = 0; i < count; i++)
            send_request(random_request());
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // receiver: random stalls plus an occasional long hold-off
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end
        else
            res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // checker: each byte against the oldest owed one
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            bytes_checked++;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte %h last %b", $time,
                         res_bus.out_byte, res_bus.last);
                errors++;
            end
            else
            begin
                want_byte = pending_bytes.pop_front();
                if (res_bus.out_byte !== want_byte.data)
                begin
                    $display("%0t: out_byte mismatch, expected %h, got %h", $time,
                             want_byte.data, res_bus.out_byte);
                    errors++;
                end
                if (res_bus.last !== want_byte.last)
                begin
                    $display("%0t: last mismatch, expected %b, got %b", $time,
                             want_byte.last, res_bus.last);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: no handshake for too long while a request or byte is open
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (pending_bytes.size() == 0 && !item_bus.valid))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d bytes still owed", $time,
                     IDLE_LIMIT, pending_bytes.size());
            $display("ubjson_value_encoder_test: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int directed_count;
        item_bus.valid = 1'b0;
        item_bus.mode  = MODE_NULL;
        item_bus.value = '0;
        res_bus.ready  = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, back to back with a free-running receiver
        build_directed();
        directed_count = directed_requests.size();
        foreach (directed_requests[i])
            send_request(directed_requests[i]);
        wait_drained();

        // random part: no idling, idle sender, stalling receiver, both, long hold
        run_phase(0, 0, 1'b0, PHASE_ITEMS);
        run_phase(77, 0, 1'b0, PHASE_ITEMS);
        run_phase(0, 77, 1'b0, PHASE_ITEMS);
        run_phase(36, 36, 1'b0, PHASE_ITEMS);
        run_phase(0, 0, 1'b1, PHASE_ITEMS);

        // catch stray bytes after the last value
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d directed) over all modes and idle patterns,",
                 requests_sent, directed_count);
        $display("%0d bytes checked, %0d string headers, %0d non-finite floats",
                 bytes_checked, string_headers, nonfinite_floats);
        if (errors == 0)
            $display("ubjson_value_encoder_test: done, clean");
        else
            $display("ubjson_value_encoder_test: done, errors");
        $finish;
    end

endmodule

### ubjson_value_encoder.f
sv/ubjv_pkg.sv
sv/ubjv_if.sv
sv/ubjv_format.sv
sv/ubjv_serializer.sv
sv/ubjson_value_encoder.sv
dv/ubjson_value_encoder_test.sv
